// ===== rtl/xor_decrypt_adler32_verify_unit_assert.svh =====
// Assertion macros used by the xdav top-level RTL file.
`ifndef XOR_DECRYPT_ADLER32_VERIFY_UNIT_ASSERT_SVH
`define XOR_DECRYPT_ADLER32_VERIFY_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Check on every clock edge outside reset.
`define XDAV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check on every clock edge, reset included.
`define XDAV_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define XDAV_ASSERT(lbl, prop, msg)
`define XDAV_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/xdav_pkg.sv =====
// Package with beat types and constants of the XOR decrypt and Adler-32 verify unit.
`default_nettype none
package xdav_pkg;

	// Adler-32 modulus
	localparam logic [15:0] ADLER_MOD = 16'd65521;

	// Key position register width (up to sixteen key bytes)
	localparam int KEY_POS_W = 4;

	// Configuration address: registers at 8 * index
	localparam int PADDR_W = 4;
	localparam int CFG_SEL_BIT = 3;
	localparam logic REG_KEY_LOW = 1'b0;
	localparam logic REG_KEY_HIGH = 1'b1;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        encrypted;
		logic        first;
		logic        last;
		logic [31:0] expected_sum;
	} in_beat_t;

	typedef struct packed {
		logic [7:0]  plain_byte;
		logic        end_of_entry;
		logic [31:0] sum_value;
		logic        sum_ok;
	} out_beat_t;

endpackage
`default_nettype wire

// ===== rtl/xdav_apb_regs.sv =====
// APB register file holding the two 64-bit key words.
`default_nettype none
module xdav_apb_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [xdav_pkg::PADDR_W-1:0] paddr,
	input  wire logic [63:0]                  pwdata,
	output logic      [63:0]                  prdata,
	output logic                              pready,
	output logic      [63:0]                  key_low,
	output logic      [63:0]                  key_high
);

	logic [63:0] key_low_q;
	logic [63:0] key_high_q;
	logic        wr_en;
	logic        reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = paddr[xdav_pkg::CFG_SEL_BIT];

	// Write the addressed key word in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				xdav_pkg::REG_KEY_LOW:  key_low_q  <= pwdata;
				xdav_pkg::REG_KEY_HIGH: key_high_q <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back the addressed key word
	always_comb begin
		case (reg_sel)
			xdav_pkg::REG_KEY_LOW:  prdata = key_low_q;
			xdav_pkg::REG_KEY_HIGH: prdata = key_high_q;
			default:                prdata = '0;
		endcase
	end

	assign key_low  = key_low_q;
	assign key_high = key_high_q;

endmodule
`default_nettype wire

// ===== rtl/xor_decrypt_adler32_verify_unit.sv =====
// Top level: repeating-key XOR decryption with running Adler-32 check.
// An accepted input beat is held in the input stage; its result beat is then offered from the result register.
// Throughput: one byte per cycle while out_ready holds; the sum update is one add-compare-subtract
// for a and one for b between the input stage and the result register.
// Reset: asynchronous, active low; clears both stages, key words, key position,
// sum a to one and sum b to zero.
`default_nettype none
`include "xor_decrypt_adler32_verify_unit_assert.svh"
module xor_decrypt_adler32_verify_unit #(
	parameter int KEY_BYTES = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// input byte channel
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire xdav_pkg::in_beat_t           in_data,
	// result channel
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output xdav_pkg::out_beat_t               out_data,
	// configuration port
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [xdav_pkg::PADDR_W-1:0] paddr,
	input  wire logic [63:0]                  pwdata,
	output logic      [63:0]                  prdata,
	output logic                              pready
);

	localparam int POS_W = xdav_pkg::KEY_POS_W;
	localparam logic [POS_W:0] KEY_WRAP = (POS_W+1)'(KEY_BYTES);

	logic [63:0] key_low;
	logic [63:0] key_high;

	xdav_apb_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.key_low  (key_low),
		.key_high (key_high)
	);

	// Pipeline registers and running state
	logic                valid_s1;
	xdav_pkg::in_beat_t  beat_s1;
	logic                valid_s2;
	xdav_pkg::out_beat_t beat_s2;
	logic [POS_W-1:0]    key_pos_q;
	logic [15:0]         sum_a_q;
	logic [15:0]         sum_b_q;

	// Stage-one datapath
	logic                advance;
	logic [POS_W-1:0]    pos_base;
	logic [POS_W:0]      pos_inc;
	logic [POS_W-1:0]    pos_next;
	logic [63:0]         key_word;
	logic [7:0]          key_byte;
	logic [7:0]          plain;
	logic [15:0]         a_base;
	logic [15:0]         b_base;
	logic [16:0]         a_sum;
	logic [15:0]         a_next;
	logic [16:0]         b_sum;
	logic [15:0]         b_next;
	logic [31:0]         sum_word;
	xdav_pkg::out_beat_t result;

	// Handshake: stage one moves on when the result register is free or drained
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		// restart the entry on the first byte
		pos_base = beat_s1.first ? '0 : key_pos_q;
		a_base   = beat_s1.first ? 16'd1 : sum_a_q;
		b_base   = beat_s1.first ? 16'd0 : sum_b_q;

		// pick the key byte at the current position
		key_word = pos_base[POS_W-1] ? key_high : key_low;
		key_byte = key_word[{pos_base[POS_W-2:0], 3'b000} +: 8];
		plain    = beat_s1.encrypted ? (beat_s1.data_byte ^ key_byte) : beat_s1.data_byte;

		// advance the key position on encrypted bytes, wrap at the key length
		pos_inc  = {1'b0, pos_base} + (POS_W+1)'(1);
		if (!beat_s1.encrypted) begin
			pos_next = pos_base;
		end else if (pos_inc >= KEY_WRAP) begin
			pos_next = '0;
		end else begin
			pos_next = pos_inc[POS_W-1:0];
		end

		// fold the byte into the sums, one compare-subtract each
		a_sum  = {1'b0, a_base} + {9'd0, plain};
		a_next = (a_sum >= {1'b0, xdav_pkg::ADLER_MOD}) ?
			16'(a_sum - {1'b0, xdav_pkg::ADLER_MOD}) : a_sum[15:0];
		b_sum  = {1'b0, b_base} + {1'b0, a_next};
		b_next = (b_sum >= {1'b0, xdav_pkg::ADLER_MOD}) ?
			16'(b_sum - {1'b0, xdav_pkg::ADLER_MOD}) : b_sum[15:0];

		sum_word            = {b_next, a_next};
		result.plain_byte   = plain;
		result.end_of_entry = beat_s1.last;
		result.sum_value    = sum_word;
		result.sum_ok       = beat_s1.last && (sum_word == beat_s1.expected_sum);
	end

	// Control: stage valids and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			key_pos_q <= '0;
			sum_a_q   <= 16'd1;
			sum_b_q   <= 16'd0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2  <= 1'b1;
				key_pos_q <= pos_next;
				sum_a_q   <= a_next;
				sum_b_q   <= b_next;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload: capture the input beat and the result beat
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s1 <= in_data;
		end
		if (advance) begin
			beat_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = beat_s2;

	// Checks on the running state and results
	`XDAV_ASSERT(a_sum_a_range, sum_a_q < xdav_pkg::ADLER_MOD, "sum a out of range")
	`XDAV_ASSERT(a_sum_b_range, sum_b_q < xdav_pkg::ADLER_MOD, "sum b out of range")
	`XDAV_ASSERT(a_key_pos_range, {1'b0, key_pos_q} < KEY_WRAP, "key position past key length")
	`XDAV_ASSERT(a_ok_only_last, (valid_s2 && !beat_s2.end_of_entry) |-> !beat_s2.sum_ok, "sum_ok on a byte that is not last")
	`XDAV_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> (!valid_s1 && !valid_s2), "pipeline not empty in reset")

endmodule
`default_nettype wire
